// ===== hw/rtl/volume_trilinear_sampler_macros.svh =====
// assertion macros for the volume trilinear sampler
`ifndef VOLUME_TRILINEAR_SAMPLER_MACROS_SVH
`define VOLUME_TRILINEAR_SAMPLER_MACROS_SVH

// implication checked on every clock edge outside reset
`define VTS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define VTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/vts_pkg.sv =====
// shared types and constants for the volume trilinear sampler
`timescale 1ns / 1ps
package vts_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned SpaceW = 31;
  localparam int unsigned ValW = 16;
  localparam int unsigned WgtW = 16;
  localparam int unsigned CfgIdxW = 3;
  // divider dividend: 33-bit offset, or a 31-bit remainder times 65536
  localparam int unsigned DivW = 47;

  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPACE_X = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPACE_Y = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SPACE_Z = 3'd5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture request, compute offsets
    logic div_start; // begin divisions
    logic box_chk;   // register box test
    logic addr_prep; // compute base index and steps
    logic fetch;     // issue corner read
    logic mul1;      // weight products
    logic mul2;      // value products
    logic acc;       // accumulate corner
    logic acc_clr;   // clear accumulator
    logic finish;    // drive result
    logic fin_out;   // drive out-of-box result
  } vts_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
    logic outside;
  } vts_sts_t;
endpackage

// ===== hw/rtl/vts_divider.sv =====
// restoring divider, one quotient bit per cycle, three axes in parallel
`timescale 1ns / 1ps
module vts_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [3*vts_pkg::DivW-1:0] dvd,
  input  logic [3*vts_pkg::SpaceW-1:0] dvs,
  output logic                       done,
  output logic [3*vts_pkg::DivW-1:0] quo,
  output logic [3*vts_pkg::SpaceW-1:0] rem
);
  import vts_pkg::*;
  // dividend: offset on the first pass, remainder times 65536 on the second
  localparam int unsigned DW = DivW;
  localparam int unsigned CntW = 6;

  logic [DW-1:0]     q_r [3];
  logic [DW-1:0]     q_nxt [3];
  logic [SpaceW:0]   r_r [3];
  logic [SpaceW:0]   r_nxt [3];
  logic [SpaceW:0]   t [3];
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;

  // one step per axis
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      t[a] = {r_r[a][SpaceW-1:0], q_r[a][DW-1]};
      if (t[a] >= {1'b0, dvs[a*SpaceW +: SpaceW]}) begin
        r_nxt[a] = t[a] - {1'b0, dvs[a*SpaceW +: SpaceW]};
        q_nxt[a] = {q_r[a][DW-2:0], 1'b1};
      end else begin
        r_nxt[a] = t[a];
        q_nxt[a] = {q_r[a][DW-2:0], 1'b0};
      end
    end
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = CntW'(DW);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // quotient and remainder shift registers
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      if (start) begin
        q_r[a] <= dvd[a*DW +: DW];
        r_r[a] <= '0;
      end else if (busy_r) begin
        q_r[a] <= q_nxt[a];
        r_r[a] <= r_nxt[a];
      end
    end
  end

  assign done = !busy_r && !start;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      quo[a*DW +: DW] = q_r[a];
      rem[a*SpaceW +: SpaceW] = r_r[a][SpaceW-1:0];
    end
  end
endmodule

// ===== hw/rtl/vts_datapath.sv =====
// datapath: box test, cell and weight divisions, corner fetch and blend
`timescale 1ns / 1ps
module vts_datapath #(
  parameter int unsigned DIM_X = 32,
  parameter int unsigned DIM_Y = 32,
  parameter int unsigned DIM_Z = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  vts_pkg::vts_cmd_t          cmd,
  output vts_pkg::vts_sts_t          sts,
  input  logic                       wr_en,
  input  logic [14:0]                wr_addr,
  input  logic signed [15:0]         wr_val,
  input  logic                       dv_first,
  input  logic [2:0]                 corner,
  input  logic signed [31:0]         cx,
  input  logic signed [31:0]         cy,
  input  logic signed [31:0]         cz,
  input  logic signed [31:0]         org_x,
  input  logic signed [31:0]         org_y,
  input  logic signed [31:0]         org_z,
  input  logic [30:0]                sp_x,
  input  logic [30:0]                sp_y,
  input  logic [30:0]                sp_z,
  output logic                       res_valid,
  output logic signed [31:0]         res_sample,
  output logic                       res_outside
);
  import vts_pkg::*;
  localparam int unsigned Depth = DIM_X * DIM_Y * DIM_Z;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned DW = DivW;

  logic signed [ValW-1:0] mem [Depth];
  logic signed [ValW-1:0] rd_r;
  logic signed [ValW-1:0] rd_d_r;

  logic signed [32:0] d_r [3];
  logic [SpaceW-1:0]  spn [3];
  logic [SpaceW-1:0]  spn_r [3];
  logic signed [31:0] crd [3];
  logic signed [31:0] org [3];
  logic               out_r;
  logic [8:0]         dm1 [3];
  logic [3*DW-1:0]    dvd;
  logic [3*SpaceW-1:0] dvs;
  logic [3*DW-1:0]    quo;
  logic [3*SpaceW-1:0] rem;
  logic               div_start_q;
  logic               ddone;
  logic [8:0]         idx_r [3];
  logic [WgtW-1:0]    wt_r [3];
  logic [8:0]         iq [3];
  logic [AW-1:0]      base_r, stx_r, sty_r, stz_r, addr;
  logic [16:0]        f [3];
  logic [33:0]        w01_r;
  logic [16:0]        f2_r;
  logic [50:0]        w_r;
  logic signed [67:0] p_r;
  logic signed [67:0] acc_r;
  logic [63:0]        rnd;

  assign crd[0] = cx;
  assign crd[1] = cy;
  assign crd[2] = cz;
  assign org[0] = org_x;
  assign org[1] = org_y;
  assign org[2] = org_z;
  assign spn[0] = (sp_x == '0) ? SpaceW'(1) : sp_x;
  assign spn[1] = (sp_y == '0) ? SpaceW'(1) : sp_y;
  assign spn[2] = (sp_z == '0) ? SpaceW'(1) : sp_z;
  assign dm1[0] = 9'(DIM_X - 1);
  assign dm1[1] = 9'(DIM_Y - 1);
  assign dm1[2] = 9'(DIM_Z - 1);

  // offsets from origin
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int a = 0; a < 3; a++) begin
        d_r[a] <= 33'(crd[a]) - 33'(org[a]);
        spn_r[a] <= spn[a];
      end
    end
  end

  // box test: d >= 0 and floor(d/sp) within dim-1 with zero remainder at the edge
  always_ff @(posedge clk) begin
    logic o;
    o = 1'b0;
    if (cmd.box_chk) begin
      for (int a = 0; a < 3; a++) begin
        if (d_r[a][32]) o = 1'b1;
        else if (quo[a*DW +: DW] > DW'(dm1[a])) o = 1'b1;
        else if (quo[a*DW +: DW] == DW'(dm1[a]) &&
                 rem[a*SpaceW +: SpaceW] != '0) o = 1'b1;
      end
      out_r <= o;
    end
  end
  assign sts.outside = out_r;

  // divider feeds: first pass offset/spacing, second pass remainder*65536/spacing
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dvs[a*SpaceW +: SpaceW] = spn_r[a];
      if (dv_first) dvd[a*DW +: DW] = DW'({1'b0, d_r[a]});
      else dvd[a*DW +: DW] = DW'({rem[a*SpaceW +: SpaceW], 16'b0});
    end
  end

  vts_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dvd(dvd), .dvs(dvs),
    .done(ddone), .quo(quo), .rem(rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) div_start_q <= 1'b0;
    else div_start_q <= cmd.div_start;
  end
  assign sts.div_done = ddone && !div_start_q;

  // capture cell index after the first pass, weight after the second
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      iq[a] = (quo[a*DW +: DW] > DW'(dm1[a])) ? dm1[a] : quo[a*DW+:9];
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.box_chk) begin
      for (int a = 0; a < 3; a++) idx_r[a] <= iq[a];
    end
    if (cmd.addr_prep) begin
      for (int a = 0; a < 3; a++) begin
        wt_r[a] <= (quo[a*DW +: DW] > DW'(16'hFFFF)) ? 16'hFFFF : quo[a*DW +: 16];
      end
      base_r <= AW'(idx_r[0]) + AW'(DIM_X) * (AW'(idx_r[1]) + AW'(DIM_Y) * AW'(idx_r[2]));
      stx_r <= (idx_r[0] >= dm1[0]) ? '0 : AW'(1);
      sty_r <= (idx_r[1] >= dm1[1]) ? '0 : AW'(DIM_X);
      stz_r <= (idx_r[2] >= dm1[2]) ? '0 : AW'(DIM_X * DIM_Y);
    end
  end

  // corner address and store access
  assign addr = base_r + (corner[0] ? stx_r : '0) + (corner[1] ? sty_r : '0) +
                (corner[2] ? stz_r : '0);
  always_ff @(posedge clk) begin
    if (wr_en && 32'(wr_addr) < 32'(Depth)) mem[wr_addr[AW-1:0]] <= wr_val;
    if (cmd.fetch) rd_r <= mem[addr];
  end

  // weight products, a register after each multiply
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      f[a] = corner[a] ? {1'b0, wt_r[a]} : (17'h10000 - {1'b0, wt_r[a]});
    end
  end
  // voxel value is delayed one stage to line up with its weight
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      w01_r <= f[0] * f[1];
      f2_r <= f[2];
    end
    if (cmd.mul1) begin
      w_r <= 51'(w01_r) * 51'(f2_r);
      rd_d_r <= rd_r;
    end
    if (cmd.mul2) p_r <= 68'(rd_d_r) * $signed({17'b0, w_r});
  end

  // accumulate and round to Q16.16
  always_ff @(posedge clk) begin
    if (cmd.acc_clr) acc_r <= '0;
    else if (cmd.acc) acc_r <= acc_r + p_r;
  end
  assign rnd = 64'(acc_r + 68'sh80000000);

  always_ff @(posedge clk) begin
    if (!rst_n) res_valid <= 1'b0;
    else res_valid <= cmd.finish || cmd.fin_out;
  end
  always_ff @(posedge clk) begin
    if (cmd.fin_out) begin
      res_sample <= '0;
      res_outside <= 1'b1;
    end else if (cmd.finish) begin
      res_sample <= rnd[63:32];
      res_outside <= 1'b0;
    end
  end
endmodule

// ===== hw/rtl/vts_ctrl.sv =====
// controller: sequences divisions, box test and the eight corner reads
`timescale 1ns / 1ps
module vts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              op,
  output logic              busy,
  output logic              dv_first,
  output logic [2:0]        corner,
  output vts_pkg::vts_cmd_t cmd,
  input  vts_pkg::vts_sts_t sts
);
  import vts_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DIV1 = 9'b000000010,
    S_BOX  = 9'b000000100,
    S_DIV2 = 9'b000001000,
    S_PREP = 9'b000010000,
    S_RUN  = 9'b000100000,
    S_DONE = 9'b001000000,
    S_OUT  = 9'b010000000,
    S_LD   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    dv_first = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (start && op == OP_QUERY) begin
          cmd.load = 1'b1;
          state_nxt = S_LD;
        end
      end
      S_LD: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DIV1;
      end
      S_DIV1: begin
        if (sts.div_done) begin
          cmd.box_chk = 1'b1;
          state_nxt = S_BOX;
        end
      end
      S_BOX: begin
        if (sts.outside) state_nxt = S_OUT;
        else begin
          cmd.div_start = 1'b1;
          dv_first = 1'b0;
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        dv_first = 1'b0;
        if (sts.div_done) begin
          cmd.addr_prep = 1'b1;
          cmd.acc_clr = 1'b1;
          cnt_nxt = '0;
          state_nxt = S_PREP;
        end
      end
      S_PREP: state_nxt = S_RUN;
      S_RUN: begin
        // corner k fetched at cnt k, then its weight product, value product and accumulation follow in order
        cmd.fetch = (cnt_r < 4'd8);
        cmd.mul1 = (cnt_r >= 4'd1 && cnt_r <= 4'd8);
        cmd.mul2 = (cnt_r >= 4'd2 && cnt_r <= 4'd9);
        cmd.acc = (cnt_r >= 4'd3);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 4'd10) state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt = S_IDLE;
      end
      S_OUT: begin
        cmd.fin_out = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign corner = cnt_r[2:0];
  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

// ===== hw/rtl/volume_trilinear_sampler.sv =====
// top level of the volume trilinear sampler
//  channel  direction  ports
//  in       request    start, busy, in_operation, in_voxel_address, in_voxel_value, in_coord_*
//  out      result     out_valid, out_sample, out_outside_box
//  cfg      write      cfg_we, cfg_index, cfg_data
// a voxel write is taken while busy stays low
// a query result comes as busy falls, after two 47-step restoring divisions
// (cell index, then weight) with the box test between them, then eight corner
// reads from the voxel store
// an out-of-box query returns after the first division and the box test
// synchronous active-low reset clears control state; the voxel store is not cleared
`timescale 1ns / 1ps
module volume_trilinear_sampler #(
  parameter int unsigned DIM_X = 32,
  parameter int unsigned DIM_Y = 32,
  parameter int unsigned DIM_Z = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [14:0] in_voxel_address,
  input  logic signed [15:0] in_voxel_value,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  output logic        out_valid,
  output logic signed [31:0] out_sample,
  output logic        out_outside_box,
  input  logic        cfg_we,
  input  logic [vts_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import vts_pkg::*;
  `include "volume_trilinear_sampler_macros.svh"

  logic signed [31:0] org_x_r, org_y_r, org_z_r;
  logic [30:0] sp_x_r, sp_y_r, sp_z_r;
  vts_cmd_t cmd;
  vts_sts_t sts;
  logic dv_first;
  logic [2:0] corner;
  logic accept;

  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0;
      org_y_r <= '0;
      org_z_r <= '0;
      sp_x_r <= 31'd65536;
      sp_y_r <= 31'd65536;
      sp_z_r <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X: org_x_r <= cfg_data;
        CFG_ORIGIN_Y: org_y_r <= cfg_data;
        CFG_ORIGIN_Z: org_z_r <= cfg_data;
        CFG_SPACE_X: sp_x_r <= cfg_data[30:0];
        CFG_SPACE_Y: sp_y_r <= cfg_data[30:0];
        CFG_SPACE_Z: sp_z_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  vts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .op(in_operation), .busy(busy),
    .dv_first(dv_first), .corner(corner), .cmd(cmd), .sts(sts)
  );

  vts_datapath #(.DIM_X(DIM_X), .DIM_Y(DIM_Y), .DIM_Z(DIM_Z)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .wr_en(accept && in_operation == OP_WRITE), .wr_addr(in_voxel_address),
    .wr_val(in_voxel_value), .dv_first(dv_first), .corner(corner),
    .cx(in_coord_x), .cy(in_coord_y), .cz(in_coord_z),
    .org_x(org_x_r), .org_y(org_y_r), .org_z(org_z_r),
    .sp_x(sp_x_r), .sp_y(sp_y_r), .sp_z(sp_z_r),
    .res_valid(out_valid), .res_sample(out_sample), .res_outside(out_outside_box)
  );

  // checks
  `VTS_ASSERT_IMP(a_out_zero, out_valid && out_outside_box, out_sample == '0)
  `VTS_ASSERT_NEXT(a_write_idle, accept && in_operation == OP_WRITE, !busy)
  `VTS_ASSERT_NEXT(a_query_busy, accept && in_operation == OP_QUERY, busy)
  `VTS_ASSERT_NEXT(a_one_result, out_valid, !out_valid)
endmodule

// ===== tb/trilinear_sample_checker.sv =====
// checker for the volume trilinear sampler: predicts each query and compares results
`timescale 1ns / 1ps
module trilinear_sample_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_operation,
  input  logic [14:0]        in_voxel_address,
  input  logic signed [15:0] in_voxel_value,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  input  logic               out_valid,
  input  logic signed [31:0] out_sample,
  input  logic               out_outside_box,
  input  logic               cfg_we,
  input  logic [vts_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  import vts_pkg::*;

  localparam int LastPlane = 31;
  localparam int unsigned RowStep = 32;
  localparam int unsigned SliceStep = 1024;

  typedef struct {
    logic signed [31:0] sample;
    logic               outside;
  } sample_t;

  sample_t            expected_samples[$];
  logic signed [15:0] voxel_mirror [0:32767];
  logic signed [31:0] box_origin [3];
  logic [30:0]        voxel_spacing [3];

  initial begin
    fail_count = 0;
    pending = 0;
    for (int n = 0; n < 32768; n++) voxel_mirror[n] = '0;
  end

  // trilinear blend of the eight corners around one query point
  function automatic sample_t blend_corners(logic signed [31:0] cx, logic signed [31:0] cy,
                                            logic signed [31:0] cz);
    sample_t res;
    longint coord [3];
    longint d;
    longint unsigned sp, i, r, w;
    longint unsigned wt [3];
    int unsigned idx [3];
    int unsigned stp [3];
    int unsigned base, corner;
    longint acc;
    logic [63:0] u;
    res.sample = '0;
    res.outside = 1'b0;
    coord[0] = cx;
    coord[1] = cy;
    coord[2] = cz;
    // box test, inclusive at both ends
    for (int a = 0; a < 3; a++) begin
      sp = (voxel_spacing[a] == 0) ? 1 : voxel_spacing[a];
      if (coord[a] < longint'(box_origin[a]) ||
          coord[a] > longint'(box_origin[a]) + longint'(sp) * longint'(LastPlane))
        res.outside = 1'b1;
    end
    if (res.outside) return res;
    // base cell and fractional weight per axis
    for (int a = 0; a < 3; a++) begin
      sp = (voxel_spacing[a] == 0) ? 1 : voxel_spacing[a];
      d = coord[a] - longint'(box_origin[a]);
      i = longint'(d) / sp;
      r = longint'(d) - i * sp;
      if (i > LastPlane) i = LastPlane;
      idx[a] = 32'(i);
      wt[a] = (r * 65536) / sp;
      if (wt[a] > 65535) wt[a] = 65535;
    end
    // upper corner reuses the base index at the last plane
    stp[0] = (idx[0] >= LastPlane) ? 0 : 1;
    stp[1] = (idx[1] >= LastPlane) ? 0 : RowStep;
    stp[2] = (idx[2] >= LastPlane) ? 0 : SliceStep;
    base = idx[0] + RowStep * idx[1] + SliceStep * idx[2];
    acc = 0;
    for (int k = 0; k < 8; k++) begin
      w = 1;
      corner = base;
      for (int a = 0; a < 3; a++) begin
        if (((k >> a) & 1) != 0) begin
          corner += stp[a];
          w = w * wt[a];
        end else begin
          w = w * (65536 - wt[a]);
        end
      end
      acc += longint'(voxel_mirror[corner[14:0]]) * longint'(w);
    end
    // round half up from Q16.48 to Q16.16
    u = acc + 64'h8000_0000_0000_0000;
    u = ((u + 64'h8000_0000) >> 32) - 64'h8000_0000;
    res.sample = u[31:0];
    return res;
  endfunction

  // track config, mirror voxel writes, predict and compare
  always @(posedge clk) begin
    sample_t exp_s;
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        box_origin[a] = '0;
        voxel_spacing[a] = 31'd65536;
      end
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ORIGIN_X: box_origin[0] = cfg_data;
          CFG_ORIGIN_Y: box_origin[1] = cfg_data;
          CFG_ORIGIN_Z: box_origin[2] = cfg_data;
          CFG_SPACE_X: voxel_spacing[0] = cfg_data[30:0];
          CFG_SPACE_Y: voxel_spacing[1] = cfg_data[30:0];
          CFG_SPACE_Z: voxel_spacing[2] = cfg_data[30:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected result: sample %0d outside_box %0b", out_sample, out_outside_box);
          fail_count++;
        end else begin
          exp_s = expected_samples.pop_front();
          if (out_sample !== exp_s.sample) begin
            $error("sample expected %0d actual %0d", exp_s.sample, out_sample);
            fail_count++;
          end
          if (out_outside_box !== exp_s.outside) begin
            $error("outside_box expected %0b actual %0b", exp_s.outside, out_outside_box);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        if (in_operation == OP_WRITE)
          voxel_mirror[in_voxel_address] = in_voxel_value;
        else
          expected_samples.push_back(blend_corners(in_coord_x, in_coord_y, in_coord_z));
      end
    end
    pending = expected_samples.size();
  end
endmodule

// ===== tb/tb_top.sv =====
// top of the volume trilinear sampler testbench: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module tb_top;
  import vts_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int DrainCycles = 100;
  localparam int RandomPerSetting = 256;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_operation = OP_WRITE;
  logic [14:0]        in_voxel_address = '0;
  logic signed [15:0] in_voxel_value = '0;
  logic signed [31:0] in_coord_x = '0;
  logic signed [31:0] in_coord_y = '0;
  logic signed [31:0] in_coord_z = '0;
  logic               out_valid;
  logic signed [31:0] out_sample;
  logic               out_outside_box;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CFG_ORIGIN_X;
  logic [31:0]        cfg_data = '0;
  int                 fail_count;
  int                 pending;
  int                 requests_sent = 0;
  int                 stall_cycles = 0;
  longint             cur_origin [3];
  longint             cur_spacing [3];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  volume_trilinear_sampler dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_voxel_address(in_voxel_address),
    .in_voxel_value(in_voxel_value), .in_coord_x(in_coord_x),
    .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .out_valid(out_valid), .out_sample(out_sample), .out_outside_box(out_outside_box),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  trilinear_sample_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_voxel_address(in_voxel_address),
    .in_voxel_value(in_voxel_value), .in_coord_x(in_coord_x),
    .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .out_valid(out_valid), .out_sample(out_sample), .out_outside_box(out_outside_box),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // watchdog on cycles with no request, result or register write
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || cfg_we) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchdogLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [14:0] voxel_addr(int x, int y, int z);
    return 15'(x + 32 * (y + 32 * z));
  endfunction

  // planes that are loaded: cells based on them only touch written voxels
  function automatic int pick_plane();
    int sel;
    sel = $urandom_range(3, 0);
    return (sel == 0) ? 0 : (sel == 1) ? 1 : (sel == 2) ? 30 : 31;
  endfunction

  // one request, held until accepted; the sender may idle first
  task automatic send_request(logic op, logic [14:0] addr, logic signed [15:0] val,
                              logic signed [31:0] cx, logic signed [31:0] cy,
                              logic signed [31:0] cz);
    int idle_pct;
    idle_pct = (requests_sent < 700) ? 37 : (requests_sent < 1400) ? 81 : 0;
    if ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_voxel_address <= addr;
    in_voxel_value <= val;
    in_coord_x <= cx;
    in_coord_y <= cy;
    in_coord_z <= cz;
    do @(negedge clk); while (busy);
    @(posedge clk);
    requests_sent++;
  endtask

  task automatic write_voxel(logic [14:0] addr, logic signed [15:0] val);
    send_request(OP_WRITE, addr, val, $urandom, $urandom, $urandom);
  endtask

  // coordinate on one axis, inside a loaded cell or just off the box
  function automatic logic signed [31:0] axis_coord(int a, bit off_box);
    longint c;
    longint sp;
    int plane;
    int unsigned frac;
    sp = cur_spacing[a];
    if (off_box) begin
      case ($urandom_range(2, 0))
        0: c = cur_origin[a] - 1;
        1: c = cur_origin[a] + 31 * sp + 1;
        default: c = longint'(signed'($urandom));
      endcase
      // keep it off the box where the coordinate range allows
      if (c >= cur_origin[a] && c <= cur_origin[a] + 31 * sp) c = cur_origin[a] - 1;
      if (c < -64'sd2147483648) c = cur_origin[a] + 31 * sp + 1;
    end else begin
      plane = pick_plane();
      case ($urandom_range(7, 0))
        0: frac = 0;
        1: frac = 32'(sp - 1);
        default: frac = $urandom_range(int'(sp - 1), 0);
      endcase
      if (plane == 31) frac = 0;
      c = cur_origin[a] + plane * sp + frac;
    end
    // the box origin is always a loaded point in range
    if (c < -64'sd2147483648 || c > 64'sd2147483647) c = cur_origin[a];
    return c[31:0];
  endfunction

  task automatic random_query();
    int off_axis;
    off_axis = ($urandom_range(4, 0) == 0) ? $urandom_range(2, 0) : -1;
    send_request(OP_QUERY, 15'($urandom), 16'($urandom), axis_coord(0, off_axis == 0),
                 axis_coord(1, off_axis == 1), axis_coord(2, off_axis == 2));
  endtask

  // wait for every expected result, then for any write still in flight
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // program one register setting while the block is idle
  task automatic apply_setting(int p);
    logic [31:0] o [3];
    logic [31:0] s [3];
    for (int a = 0; a < 3; a++) begin
      case (p)
        0: begin o[a] = 32'd0; s[a] = 32'd65536; end
        1: begin o[a] = $urandom_range(2097152, 0) - 1048576; s[a] = $urandom_range(262144, 1); end
        2: begin o[a] = 32'h8000_0000; s[a] = 32'd1; end
        3: begin o[a] = 32'h7FFF_FFFF; s[a] = 32'd0; end
        4: begin o[a] = 32'h8000_0000; s[a] = 32'h7FFF_FFFF; end
        5: begin o[a] = $urandom; s[a] = $urandom; end
        default: begin o[a] = $urandom_range(65535, 0); s[a] = 32'h8000_0000 | $urandom_range(4, 1); end
      endcase
      cur_origin[a] = longint'(signed'(o[a]));
      cur_spacing[a] = (s[a][30:0] == 0) ? 1 : s[a][30:0];
    end
    write_reg(CFG_ORIGIN_X, o[0]);
    write_reg(CFG_ORIGIN_Y, o[1]);
    write_reg(CFG_ORIGIN_Z, o[2]);
    write_reg(CFG_SPACE_X, s[0]);
    write_reg(CFG_SPACE_Y, s[1]);
    write_reg(CFG_SPACE_Z, s[2]);
    // indexes past the last register are ignored
    if (p == 6) begin
      write_reg(CFG_SPACE_Z + 3'd1, $urandom);
      write_reg(CFG_SPACE_Z + 3'd2, $urandom);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int planes [5];
    planes = '{0, 1, 2, 30, 31};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    apply_setting(0);

    // load every voxel on the planes that queries may touch
    foreach (planes[x]) foreach (planes[y]) foreach (planes[z])
      write_voxel(voxel_addr(planes[x], planes[y], planes[z]), 16'($urandom));

    // directed: box corners, just off each face, full fraction
    send_request(OP_QUERY, 15'h7FFF, 16'sh7FFF, 32'sd0, 32'sd0, 32'sd0);
    send_request(OP_QUERY, '0, '0, 31 * 65536, 31 * 65536, 31 * 65536);
    send_request(OP_QUERY, '0, '0, -32'sd1, 32'sd0, 32'sd0);
    send_request(OP_QUERY, '0, '0, 32'sd0, -32'sd1, 32'sd0);
    send_request(OP_QUERY, '0, '0, 32'sd0, 32'sd0, -32'sd1);
    send_request(OP_QUERY, '0, '0, 31 * 65536 + 1, 32'sd0, 32'sd0);
    send_request(OP_QUERY, '0, '0, 32'sd0, 31 * 65536 + 1, 32'sd0);
    send_request(OP_QUERY, '0, '0, 32'sd0, 32'sd0, 31 * 65536 + 1);
    send_request(OP_QUERY, '0, '0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0);
    send_request(OP_QUERY, '0, '0, 65535, 65535, 65535);
    send_request(OP_QUERY, '0, '0, 30 * 65536 + 65535, 65536 + 32768, 30 * 65536 + 1);
    // a cell of all maximum values, then all minimum values
    for (int k = 0; k < 8; k++)
      write_voxel(voxel_addr(30 + k[0], 30 + k[1], 30 + k[2]), 16'sh7FFF);
    send_request(OP_QUERY, '0, '0, 30 * 65536 + 12345, 30 * 65536 + 999, 30 * 65536 + 65535);
    for (int k = 0; k < 8; k++)
      write_voxel(voxel_addr(30 + k[0], 30 + k[1], 30 + k[2]), -16'sh8000);
    send_request(OP_QUERY, '0, '0, 30 * 65536 + 40000, 30 * 65536 + 1, 30 * 65536 + 65535);
    write_voxel(15'h7FFF, 16'sh1234);

    // random items over a sequence of register settings
    for (int p = 0; p < 7; p++) begin
      drain();
      apply_setting(p);
      for (int n = 0; n < RandomPerSetting; n++) begin
        if ($urandom_range(99, 0) < 35) begin
          if ($urandom_range(1, 0) == 0)
            write_voxel(voxel_addr(planes[$urandom_range(4, 0)], planes[$urandom_range(4, 0)],
                                   planes[$urandom_range(4, 0)]), 16'($urandom));
          else
            write_voxel(15'($urandom_range(32767, 0)), 16'($urandom));
        end else begin
          random_query();
        end
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
